FILE: rtl/mprc_pkg.sv
// Shared widths, codes and word layouts of the mesh point range constrainer.
// Depends on nothing; every other file of the block imports it.
package mprc_pkg;

   // Mesh geometry: index = row * GRID_WIDTH + column.
   localparam int GRID_WIDTH = 4;

   localparam int CMD_W     = 2;
   localparam int IDX_W     = 4;
   localparam int POS_W     = 24;
   localparam int CFG_W     = 23;
   localparam int CSR_IDX_W = 2;

   localparam int OFF_W   = CFG_W + IDX_W;   // column or row offset, unsigned
   localparam int T_W     = OFF_W + 1;       // target coordinate, signed
   localparam int D_W     = T_W + 1;         // offset from target, signed
   localparam int MAG_W   = D_W;             // magnitude of that offset
   localparam int SQ_W    = 2 * MAG_W;       // one squared offset
   localparam int D2_W    = SQ_W + 2;        // squared distance, even width
   localparam int SQRT_N  = D2_W / 2;        // root bits, one per stage
   localparam int ROOT_W  = SQRT_N;
   localparam int MRSQ_W  = 2 * CFG_W;
   localparam int PROD_W  = MAG_W + CFG_W;   // |offset| * max_range
   localparam int NUM_W   = PROD_W + 1;      // dividend with rounding term
   localparam int Q_W     = CFG_W + 1;       // scaled offset magnitude
   localparam int SUM_W   = T_W + 1;         // target plus scaled offset

   typedef enum logic [CMD_W-1:0] {
      CMD_POINT   = 2'd0,
      CMD_GRAB    = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_RANGE   = 2'd0,
      CSR_TILE_WIDTH  = 2'd1,
      CSR_TILE_HEIGHT = 2'd2
   } csr_type;

   // Side information that travels alongside the root and divider pipes.
   typedef struct packed {
      logic                     clamp;
      logic                     last;
      logic                     negx;
      logic                     negy;
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [T_W-1:0]    tx;
      logic signed [T_W-1:0]    ty;
      logic [PROD_W-1:0]        prodx;
      logic [PROD_W-1:0]        prody;
   } side_type;

endpackage

FILE: rtl/mprc_sqrt_pipe.sv
// Pipelined integer square root, one root bit resolved in each stage.
// Depends on mprc_pkg for the operand and root widths.
module mprc_sqrt_pipe (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [mprc_pkg::D2_W-1:0]   radicand,
   output logic [mprc_pkg::ROOT_W-1:0] root
);
   import mprc_pkg::*;

   logic [D2_W-1:0] rem_ff [SQRT_N];
   logic [D2_W-1:0] res_ff [SQRT_N];

   for (genvar i = 0; i < SQRT_N; i++) begin : g_stage
      localparam logic [D2_W-1:0] BIT = D2_W'(1) << (2 * (SQRT_N - 1 - i));
      logic [D2_W-1:0] rem_prev, res_prev, trial, rem_in, res_in;

      if (i == 0) begin : g_first
         assign rem_prev = radicand;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign res_prev = res_ff[i-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= rem_in;
            res_ff[i] <= res_in;
         end
      end
   end

   assign root = res_ff[SQRT_N-1][ROOT_W-1:0];

endmodule

FILE: rtl/mprc_div_pipe.sv
// Pipelined restoring divider for (product + root/2) / root, one quotient
// bit per stage. Depends on mprc_pkg; a zero divisor yields a zero quotient.
module mprc_div_pipe (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [mprc_pkg::PROD_W-1:0] product,
   input  logic [mprc_pkg::ROOT_W-1:0] divisor,
   output logic [mprc_pkg::Q_W-1:0]    quotient
);
   import mprc_pkg::*;

   logic [NUM_W-1:0]  rem_ff [Q_W+1];
   logic [ROOT_W-1:0] dvs_ff [Q_W+1];
   logic [Q_W-1:0]    quo_ff [Q_W+1];

   // Entry stage adds the rounding term.
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= NUM_W'(product) + NUM_W'(divisor >> 1);
         dvs_ff[0] <= divisor;
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_stage
      localparam int SH = Q_W - k;
      logic [NUM_W-1:0] shifted;
      logic [NUM_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      always_comb begin
         shifted = NUM_W'(dvs_ff[k-1]) << SH;
         rem_in  = rem_ff[k-1];
         quo_in  = quo_ff[k-1];
         if (rem_ff[k-1] >= shifted) begin
            rem_in     = rem_ff[k-1] - shifted;
            quo_in[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            dvs_ff[k] <= dvs_ff[k-1];
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quotient = (dvs_ff[Q_W] == '0) ? '0 : quo_ff[Q_W];

endmodule

FILE: rtl/mesh_point_range_constrainer_unit.sv
// Top level of the mesh point range constrainer: input, target, distance,
// root and divider pipes, and output register. Depends on mprc_pkg.
//
// The unit takes one word per clock cycle while req_stall is low and
// returns exactly one result word per input word, in order. A point word
// is compared against its rest position, which is the held anchor's
// origin plus column and row times the tile spacing; if an anchor is held
// and the point lies at or beyond max_range, it is pulled back along its
// offset to max_range, rounded per axis, and flagged. Grab and release
// words update the anchor and echo their position. From acceptance to a
// valid result, a word passes five front stages, thirty square-root
// stages (one root bit each), a rounding stage, twenty-four divider stages
// (one quotient bit each) and the output register. The whole
// pipeline advances together whenever the output register is empty or
// being taken, so req_stall follows rsp_stall only while a result is held.
// Configuration registers may be written only while the unit is empty.
module mesh_point_range_constrainer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mprc_pkg::CMD_W-1:0]        req_command,
   input  logic [mprc_pkg::IDX_W-1:0]        req_point_index,
   input  logic signed [mprc_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [mprc_pkg::POS_W-1:0] req_pos_y,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [mprc_pkg::POS_W-1:0] rsp_new_x,
   output logic signed [mprc_pkg::POS_W-1:0] rsp_new_y,
   output logic                              rsp_was_clamped,
   output logic                              rsp_pass_clamped,
   output logic                              rsp_last_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mprc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mprc_pkg::CFG_W-1:0]        csr_data
);
   import mprc_pkg::*;

   // Side line entries: entry 0 is the compare stage, then one per root
   // stage, one for the rounding stage and one per quotient stage.
   localparam int LAT = SQRT_N + Q_W + 2;
   localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
   localparam int POS_MIN = -(2 ** (POS_W - 1));

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > POS_MAX) begin
         r = POS_W'(POS_MAX);
      end else if (v < POS_MIN) begin
         r = POS_W'(POS_MIN);
      end else begin
         r = POS_W'(v);
      end
      return r;
   endfunction

   logic advance;

   // ---------------------------------------------------------------
   // Configuration registers. The port never holds off a write.
   // ---------------------------------------------------------------
   logic [CFG_W-1:0]  max_range_ff, tile_width_ff, tile_height_ff;
   logic [MRSQ_W-1:0] mr_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff   <= CFG_W'(2560);
         tile_width_ff  <= CFG_W'(25600);
         tile_height_ff <= CFG_W'(25600);
      end else if (csr_valid && csr_ready) begin
         case (csr_type'(csr_index))
            CSR_MAX_RANGE:   max_range_ff   <= csr_data;
            CSR_TILE_WIDTH:  tile_width_ff  <= csr_data;
            CSR_TILE_HEIGHT: tile_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The squared limit settles in the cycle after a write, long before any
   // word can reach the compare stage.
   always_ff @(posedge clock) begin
      mr_sq_ff <= MRSQ_W'(max_range_ff) * MRSQ_W'(max_range_ff);
   end

   // The pipeline moves as one whenever the output register can take a word.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // ---------------------------------------------------------------
   // Stage 1: input register.
   // ---------------------------------------------------------------
   logic                    s1_valid_ff;
   logic [CMD_W-1:0]        s1_cmd_ff;
   logic [IDX_W-1:0]        s1_idx_ff;
   logic signed [POS_W-1:0] s1_px_ff, s1_py_ff;
   logic                    s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff  <= req_command;
         s1_idx_ff  <= req_point_index;
         s1_px_ff   <= req_pos_x;
         s1_py_ff   <= req_pos_y;
         s1_last_ff <= req_last_point;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: rest offsets, anchor state and target. The anchor is read
   // and written in this one stage, so every word sees the anchor left by
   // the word before it.
   // ---------------------------------------------------------------
   logic [IDX_W-1:0]        col, row;
   logic [OFF_W-1:0]        col_off, row_off;
   logic                    anchor_held_ff, anchor_held_in;
   logic signed [POS_W-1:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic signed [T_W-1:0]   s2_tx_in, s2_ty_in;
   logic                    s2_act_in;

   logic                    s2_valid_ff, s2_act_ff, s2_last_ff;
   logic signed [POS_W-1:0] s2_px_ff, s2_py_ff;
   logic signed [T_W-1:0]   s2_tx_ff, s2_ty_ff;

   always_comb begin
      col     = IDX_W'(s1_idx_ff % GRID_WIDTH);
      row     = IDX_W'(s1_idx_ff / GRID_WIDTH);
      col_off = OFF_W'(col) * OFF_W'(tile_width_ff);
      row_off = OFF_W'(row) * OFF_W'(tile_height_ff);

      s2_tx_in  = T_W'(origin_x_ff) + T_W'(col_off);
      s2_ty_in  = T_W'(origin_y_ff) + T_W'(row_off);
      s2_act_in = (cmd_type'(s1_cmd_ff) == CMD_POINT) && anchor_held_ff;

      anchor_held_in = anchor_held_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      if (advance && s1_valid_ff) begin
         case (cmd_type'(s1_cmd_ff))
            CMD_GRAB: begin
               // The origin wraps to the coordinate width.
               origin_x_in    = s1_px_ff - col_off[POS_W-1:0];
               origin_y_in    = s1_py_ff - row_off[POS_W-1:0];
               anchor_held_in = 1'b1;
            end
            CMD_RELEASE: begin
               anchor_held_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_held_ff <= 1'b0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         s2_valid_ff    <= 1'b0;
      end else begin
         anchor_held_ff <= anchor_held_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_act_ff  <= s2_act_in;
         s2_last_ff <= s1_last_ff;
         s2_px_ff   <= s1_px_ff;
         s2_py_ff   <= s1_py_ff;
         s2_tx_ff   <= s2_tx_in;
         s2_ty_ff   <= s2_ty_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: offset of the point from its target.
   // ---------------------------------------------------------------
   logic                    s3_valid_ff, s3_act_ff, s3_last_ff;
   logic signed [POS_W-1:0] s3_px_ff, s3_py_ff;
   logic signed [T_W-1:0]   s3_tx_ff, s3_ty_ff;
   logic signed [D_W-1:0]   s3_dx_ff, s3_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_act_ff  <= s2_act_ff;
         s3_last_ff <= s2_last_ff;
         s3_px_ff   <= s2_px_ff;
         s3_py_ff   <= s2_py_ff;
         s3_tx_ff   <= s2_tx_ff;
         s3_ty_ff   <= s2_ty_ff;
         s3_dx_ff   <= D_W'(s2_px_ff) - D_W'(s2_tx_ff);
         s3_dy_ff   <= D_W'(s2_py_ff) - D_W'(s2_ty_ff);
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: squares and magnitudes of the offset.
   // ---------------------------------------------------------------
   logic                    s4_valid_ff, s4_act_ff, s4_last_ff;
   logic signed [POS_W-1:0] s4_px_ff, s4_py_ff;
   logic signed [T_W-1:0]   s4_tx_ff, s4_ty_ff;
   logic [SQ_W-1:0]         s4_sqx_ff, s4_sqy_ff;
   logic [MAG_W-1:0]        s4_magx_ff, s4_magy_ff;
   logic                    s4_negx_ff, s4_negy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_act_ff  <= s3_act_ff;
         s4_last_ff <= s3_last_ff;
         s4_px_ff   <= s3_px_ff;
         s4_py_ff   <= s3_py_ff;
         s4_tx_ff   <= s3_tx_ff;
         s4_ty_ff   <= s3_ty_ff;
         s4_sqx_ff  <= SQ_W'(s3_dx_ff * s3_dx_ff);
         s4_sqy_ff  <= SQ_W'(s3_dy_ff * s3_dy_ff);
         s4_magx_ff <= s3_dx_ff[D_W-1] ? MAG_W'(-s3_dx_ff) : MAG_W'(s3_dx_ff);
         s4_magy_ff <= s3_dy_ff[D_W-1] ? MAG_W'(-s3_dy_ff) : MAG_W'(s3_dy_ff);
         s4_negx_ff <= s3_dx_ff[D_W-1];
         s4_negy_ff <= s3_dy_ff[D_W-1];
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: squared distance, range test and scaled magnitudes. This is
   // entry 0 of the side line that follows the root and divider pipes.
   // ---------------------------------------------------------------
   logic [D2_W-1:0] d2_in;
   logic [D2_W-1:0] d2_ff;
   side_type        side_in;
   side_type        side_ff [LAT];
   logic            side_valid_ff [LAT];

   always_comb begin
      d2_in         = D2_W'(s4_sqx_ff) + D2_W'(s4_sqy_ff);
      side_in.clamp = s4_act_ff && (d2_in >= D2_W'(mr_sq_ff));
      side_in.last  = s4_last_ff;
      side_in.negx  = s4_negx_ff;
      side_in.negy  = s4_negy_ff;
      side_in.px    = s4_px_ff;
      side_in.py    = s4_py_ff;
      side_in.tx    = s4_tx_ff;
      side_in.ty    = s4_ty_ff;
      side_in.prodx = PROD_W'(s4_magx_ff) * PROD_W'(max_range_ff);
      side_in.prody = PROD_W'(s4_magy_ff) * PROD_W'(max_range_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            side_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         side_valid_ff[0] <= s4_valid_ff;
         for (int i = 1; i < LAT; i++) begin
            side_valid_ff[i] <= side_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d2_ff      <= d2_in;
         side_ff[0] <= side_in;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Root and divider pipes. The root leaves in step with side entry
   // SQRT_N; the quotients leave in step with the last side entry.
   // ---------------------------------------------------------------
   logic [ROOT_W-1:0] root;
   logic [Q_W-1:0]    quot_x, quot_y;

   mprc_sqrt_pipe u_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (d2_ff),
      .root     (root)
   );

   mprc_div_pipe u_div_x (
      .clock    (clock),
      .advance  (advance),
      .product  (side_ff[SQRT_N].prodx),
      .divisor  (root),
      .quotient (quot_x)
   );

   mprc_div_pipe u_div_y (
      .clock    (clock),
      .advance  (advance),
      .product  (side_ff[SQRT_N].prody),
      .divisor  (root),
      .quotient (quot_y)
   );

   // ---------------------------------------------------------------
   // Output stage: apply the pulled-back offset with saturation, keep the
   // pass flag, and hold the result word until it is taken.
   // ---------------------------------------------------------------
   side_type                fin;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic signed [POS_W-1:0] new_x_in, new_y_in;
   logic                    any_clamped_ff, any_clamped_in, pass_in, any_or;

   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_new_x_ff, rsp_new_y_ff;
   logic                    rsp_was_clamped_ff, rsp_pass_clamped_ff, rsp_last_out_ff;

   always_comb begin
      fin   = side_ff[LAT-1];
      sum_x = SUM_W'(fin.tx) + (fin.negx ? -SUM_W'(quot_x) : SUM_W'(quot_x));
      sum_y = SUM_W'(fin.ty) + (fin.negy ? -SUM_W'(quot_y) : SUM_W'(quot_y));
      new_x_in = fin.clamp ? sat_pos(sum_x) : fin.px;
      new_y_in = fin.clamp ? sat_pos(sum_y) : fin.py;

      any_or         = any_clamped_ff || fin.clamp;
      pass_in        = fin.last && any_or;
      any_clamped_in = any_clamped_ff;
      if (advance && side_valid_ff[LAT-1]) begin
         any_clamped_in = fin.last ? 1'b0 : any_or;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         any_clamped_ff <= 1'b0;
      end else begin
         any_clamped_ff <= any_clamped_in;
         if (advance) begin
            rsp_valid_ff <= side_valid_ff[LAT-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_new_x_ff        <= new_x_in;
         rsp_new_y_ff        <= new_y_in;
         rsp_was_clamped_ff  <= fin.clamp;
         rsp_pass_clamped_ff <= pass_in;
         rsp_last_out_ff     <= fin.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_x        = rsp_new_x_ff;
   assign rsp_new_y        = rsp_new_y_ff;
   assign rsp_was_clamped  = rsp_was_clamped_ff;
   assign rsp_pass_clamped = rsp_pass_clamped_ff;
   assign rsp_last_out     = rsp_last_out_ff;

   // ---------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------

   // The pass flag only ever appears on the word that ends a pass.
   a_pass_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_out || !rsp_pass_clamped))
      else $error("pass flag on a word that does not end a pass");

   // A clamped word that ends a pass must report the pass as clamped.
   a_pass_covers_self: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_out && rsp_was_clamped) |-> rsp_pass_clamped)
      else $error("clamped last word without pass flag");

   // A release word leaving the input stage drops the anchor.
   a_release_drops: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(advance && s1_valid_ff)
       && ($past(s1_cmd_ff) == CMD_RELEASE)) |-> !anchor_held_ff)
      else $error("anchor still held after release");

   // A grab word leaving the input stage sets the anchor.
   a_grab_sets: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(advance && s1_valid_ff)
       && ($past(s1_cmd_ff) == CMD_GRAB)) |-> anchor_held_ff)
      else $error("anchor not held after grab");

   // Only a point word with an anchor held can be clamped.
   a_clamp_needs_anchor: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_act_ff) |-> $past(anchor_held_ff))
      else $error("point marked active without a held anchor");

endmodule
